// ===== rtl/i2cee_pkg.sv =====
// Shared types and codes for the I2C EEPROM byte access master.
// No dependencies; the csr, core, outq, top and checker files import this package.
package i2cee_pkg;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Command codes on the tick beat
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_BUS_ADDR          = 2'd0;
   localparam logic [1:0] REG_WAIT_SCALE        = 2'd1;
   localparam logic [1:0] REG_ACK_TIMEOUT       = 2'd2;
   localparam logic [1:0] REG_WRITE_CYCLE_TICKS = 2'd3;

   // Register reset values
   localparam logic [6:0]  RST_BUS_ADDR          = 7'd80;
   localparam logic [10:0] RST_WAIT_SCALE        = 11'd1;
   localparam logic [7:0]  RST_ACK_TIMEOUT       = 8'd250;
   localparam logic [15:0] RST_WRITE_CYCLE_TICKS = 16'd8000;

   // Byte stage inside a transaction
   localparam logic [1:0] STAGE_DEVICE = 2'd0;
   localparam logic [1:0] STAGE_WORD   = 2'd1;
   localparam logic [1:0] STAGE_SECOND = 2'd2;
   localparam logic [1:0] STAGE_READ   = 2'd3;

   typedef enum logic [15:0] {
      PH_IDLE   = 16'h0001,
      PH_STHI   = 16'h0002,
      PH_STLO   = 16'h0004,
      PH_WBLO   = 16'h0008,
      PH_WBHI   = 16'h0010,
      PH_ACKREL = 16'h0020,
      PH_ACKCLK = 16'h0040,
      PH_ACKPOL = 16'h0080,
      PH_ACKEND = 16'h0100,
      PH_RBHI   = 16'h0200,
      PH_RBLO   = 16'h0400,
      PH_NACK   = 16'h0800,
      PH_SPLO   = 16'h1000,
      PH_SPMID  = 16'h2000,
      PH_SPEND  = 16'h4000,
      PH_WCYC   = 16'h8000
   } phase_type;

   // Live configuration; hold values are pre-scaled wait lengths in ticks
   typedef struct packed {
      logic [6:0]  bus_addr;
      logic [7:0]  ack_timeout;
      logic [15:0] write_cycle_ticks;
      logic [15:0] hold2;
      logic [15:0] hold5;
      logic [15:0] hold10;
   } cfg_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_done;
      logic       ack_missed;
   } rsp_item_type;

endpackage

// ===== rtl/i2cee_if.sv =====
// Valid/ready channel interfaces for the tick beats and the result beats.
// No dependencies.
interface i2cee_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] word_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, command, word_address, write_data, sda_in, input ready);
   modport sink   (input valid, command, word_address, write_data, sda_in, output ready);
endinterface

interface i2cee_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl;
   logic       sda_out;
   logic       busy_res;
   logic [7:0] read_data;
   logic       read_done;
   logic       ack_missed;

   modport source (output valid, scl, sda_out, busy_res, read_data, read_done, ack_missed,
                   input ready);
   modport sink   (input valid, scl, sda_out, busy_res, read_data, read_done, ack_missed,
                   output ready);
endinterface

// ===== rtl/i2cee_csr.sv =====
// APB-style configuration registers; pre-scales the wait lengths on write.
// Depends on i2cee_pkg.
module i2cee_csr
   import i2cee_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [6:0]  dev_ff;
   logic [10:0] scale_ff;
   logic [7:0]  tmo_ff;
   logic [15:0] wct_ff;
   logic [15:0] hold2_ff, hold5_ff, hold10_ff;
   logic        wr;
   logic [1:0]  idx;
   logic [10:0] ws;
   logic [15:0] x2, x5, x10;

   // scaled wait of zero still lasts one tick
   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   assign wr  = psel & penable & pwrite;
   assign idx = paddr[3:2];
   assign ws  = pwdata[10:0];
   assign x2  = {4'd0, ws, 1'b0};
   assign x5  = {5'd0, ws} + {3'd0, ws, 2'b00};
   assign x10 = {x5[14:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff    <= RST_BUS_ADDR;
         scale_ff  <= RST_WAIT_SCALE;
         tmo_ff    <= RST_ACK_TIMEOUT;
         wct_ff    <= RST_WRITE_CYCLE_TICKS;
         hold2_ff  <= 16'd2;
         hold5_ff  <= 16'd5;
         hold10_ff <= 16'd10;
      end else if (wr) begin
         unique case (idx)
            REG_BUS_ADDR: dev_ff <= pwdata[6:0];
            REG_WAIT_SCALE: begin
               scale_ff  <= ws;
               hold2_ff  <= at_least_one(x2);
               hold5_ff  <= at_least_one(x5);
               hold10_ff <= at_least_one(x10);
            end
            REG_ACK_TIMEOUT:       tmo_ff <= pwdata[7:0];
            REG_WRITE_CYCLE_TICKS: wct_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_BUS_ADDR:          prdata = {25'd0, dev_ff};
         REG_WAIT_SCALE:        prdata = {21'd0, scale_ff};
         REG_ACK_TIMEOUT:       prdata = {24'd0, tmo_ff};
         REG_WRITE_CYCLE_TICKS: prdata = {16'd0, wct_ff};
         default:               prdata = '0;
      endcase
   end

   assign pready                = 1'b1;
   assign cfg.bus_addr          = dev_ff;
   assign cfg.ack_timeout       = tmo_ff;
   assign cfg.write_cycle_ticks = wct_ff;
   assign cfg.hold2             = hold2_ff;
   assign cfg.hold5             = hold5_ff;
   assign cfg.hold10            = hold10_ff;

endmodule

// ===== rtl/i2cee_core.sv =====
// Tick input register and bus sequencer: one tick beat per step.
// Depends on i2cee_pkg and i2cee_if.
module i2cee_core
   import i2cee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cee_req_if.sink    req,
   input  cfg_type      cfg,
   input  logic         q_full,
   output logic         push,
   output rsp_item_type result
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] cmd_ff;
   logic [7:0] word_ff, wdata_ff;
   logic       sda_ff;
   logic       accept, step;

   // sequencer state
   phase_type  phase_ff, phase_in;
   logic [15:0] hold_ff, hold_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] laddr_ff, laddr_in;
   logic [7:0] ldata_ff, ldata_in;
   logic       rd_ff, rd_in;
   logic [7:0] await_ff, await_in;
   logic [7:0] last_ff, last_in;
   logic [1:0] stage_ff, stage_in;

   logic       expire, go_enter;
   phase_type  target;

   function automatic logic [15:0] hold_for(input phase_type p, input cfg_type c);
      logic [15:0] h;
      unique case (p) inside
         PH_STHI, PH_STLO, PH_ACKEND, PH_SPLO, PH_SPMID: h = c.hold2;
         PH_WBHI:             h = c.hold5;
         PH_ACKREL, PH_ACKCLK: h = c.hold10;
         PH_WCYC:             h = c.write_cycle_ticks;
         default:             h = 16'd1;
      endcase
      return h;
   endfunction

   assign step      = in_valid_ff & ~q_full;
   assign req.ready = ~in_valid_ff | step;
   assign accept    = req.valid & req.ready;
   assign push      = step;

   always_comb begin
      if (accept)    in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      else           in_valid_in = in_valid_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      laddr_in = laddr_ff;
      ldata_in = ldata_ff;
      rd_in    = rd_ff;
      await_in = await_ff;
      last_in  = last_ff;
      stage_in = stage_ff;
      expire   = 1'b0;
      go_enter = 1'b0;
      target   = PH_IDLE;
      result.scl        = 1'b1;
      result.sda_out    = 1'b1;
      result.busy_res   = 1'b0;
      result.read_done  = 1'b0;
      result.ack_missed = 1'b0;

      // command is only taken while idle; code three acts as none
      if (phase_ff == PH_IDLE && (cmd_ff == CMD_WRITE || cmd_ff == CMD_READ)) begin
         laddr_in = word_ff;
         ldata_in = wdata_ff;
         rd_in    = (cmd_ff == CMD_READ);
         stage_in = STAGE_DEVICE;
         bit_in   = 3'd0;
         shift_in = {cfg.bus_addr, 1'b0};
         phase_in = PH_STHI;
         hold_in  = cfg.hold2;
      end

      if (phase_in != PH_IDLE) begin
         result.busy_res = 1'b1;
         unique case (phase_in) inside
            PH_STLO, PH_SPMID: result.sda_out = 1'b0;
            PH_WBLO: begin
               result.scl     = 1'b0;
               result.sda_out = shift_in[7];
            end
            PH_WBHI: result.sda_out = shift_in[7];
            PH_ACKREL, PH_ACKEND, PH_RBLO: result.scl = 1'b0;
            PH_SPLO: begin
               result.scl     = 1'b0;
               result.sda_out = 1'b0;
            end
            default: ;
         endcase

         if (phase_in == PH_ACKPOL) begin
            if (sda_ff) begin
               await_in = await_ff + 8'd1;
               if (await_in >= cfg.ack_timeout) begin
                  result.ack_missed = 1'b1;
                  expire            = 1'b1;
               end
            end else begin
               expire = 1'b1;
            end
         end else begin
            if (phase_in == PH_RBHI) begin
               shift_in = {shift_in[6:0], sda_ff};
               bit_in   = bit_in + 3'd1;
               if (bit_in == 3'd0) last_in = shift_in;
            end
            if (phase_in == PH_SPEND && rd_in) result.read_done = 1'b1;
            hold_in = hold_in - 16'd1;
            if (hold_in == 16'd0) expire = 1'b1;
         end

         if (expire) begin
            go_enter = 1'b1;
            unique case (phase_in)
               PH_STHI:   target = PH_STLO;
               PH_STLO:   target = PH_WBLO;
               PH_WBLO:   target = PH_WBHI;
               PH_WBHI: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 3'd1;
                  target   = (bit_in == 3'd0) ? PH_ACKREL : PH_WBLO;
               end
               PH_ACKREL: target = PH_ACKCLK;
               PH_ACKCLK: target = PH_ACKPOL;
               PH_ACKPOL: target = PH_ACKEND;
               PH_ACKEND: begin
                  // pick the next byte after the acknowledge
                  if (stage_in == STAGE_DEVICE) begin
                     shift_in = laddr_in;
                     stage_in = STAGE_WORD;
                     target   = PH_WBLO;
                  end else if (stage_in == STAGE_WORD) begin
                     stage_in = STAGE_SECOND;
                     if (rd_in) begin
                        shift_in = {cfg.bus_addr, 1'b1};
                        target   = PH_STHI;
                     end else begin
                        shift_in = ldata_in;
                        target   = PH_WBLO;
                     end
                  end else if (stage_in == STAGE_SECOND && rd_in) begin
                     shift_in = 8'd0;
                     bit_in   = 3'd0;
                     stage_in = STAGE_READ;
                     target   = PH_RBHI;
                  end else begin
                     target = PH_SPLO;
                  end
               end
               PH_RBHI:   target = PH_RBLO;
               PH_RBLO:   target = (bit_in == 3'd0) ? PH_NACK : PH_RBHI;
               PH_NACK:   target = PH_SPLO;
               PH_SPLO:   target = PH_SPMID;
               PH_SPMID:  target = PH_SPEND;
               PH_SPEND: begin
                  if (!rd_in && cfg.write_cycle_ticks != 16'd0) begin
                     target = PH_WCYC;
                  end else begin
                     go_enter = 1'b0;
                     phase_in = PH_IDLE;
                     hold_in  = 16'd0;
                  end
               end
               default: begin
                  go_enter = 1'b0;
                  phase_in = PH_IDLE;
                  hold_in  = 16'd0;
               end
            endcase
         end

         if (go_enter) begin
            phase_in = target;
            hold_in  = hold_for(target, cfg);
            if (target == PH_ACKPOL) await_in = 8'd0;
         end
      end

      result.read_data = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         hold_ff     <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         laddr_ff    <= '0;
         ldata_ff    <= '0;
         rd_ff       <= 1'b0;
         await_ff    <= '0;
         last_ff     <= '0;
         stage_ff    <= STAGE_DEVICE;
      end else begin
         in_valid_ff <= in_valid_in;
         if (step) begin
            phase_ff <= phase_in;
            hold_ff  <= hold_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            laddr_ff <= laddr_in;
            ldata_ff <= ldata_in;
            rd_ff    <= rd_in;
            await_ff <= await_in;
            last_ff  <= last_in;
            stage_ff <= stage_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req.command;
         word_ff  <= req.word_address;
         wdata_ff <= req.write_data;
         sda_ff   <= req.sda_in;
      end
   end

endmodule

// ===== rtl/i2cee_outq.sv =====
// Two-entry result buffer between the sequencer and the result channel.
// Depends on i2cee_pkg and i2cee_if.
module i2cee_outq
   import i2cee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type item,
   output logic         full,
   i2cee_rsp_if.source  rsp
);

   rsp_item_type entry_ff [2];
   logic         head_ff, head_in;
   logic [1:0]   count_ff, count_in;
   logic         pop, tail;
   rsp_item_type top;

   assign pop  = (count_ff != 2'd0) & rsp.ready;
   assign tail = head_ff ^ count_ff[0];
   assign full = (count_ff == 2'd2);
   assign top  = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[tail] <= item;
   end

   assign rsp.valid      = (count_ff != 2'd0);
   assign rsp.scl        = top.scl;
   assign rsp.sda_out    = top.sda_out;
   assign rsp.busy_res   = top.busy_res;
   assign rsp.read_data  = top.read_data;
   assign rsp.read_done  = top.read_done;
   assign rsp.ack_missed = top.ack_missed;

endmodule

// ===== rtl/i2c_eeprom_byte_access_master.sv =====
// Path: a tick beat accepted on the input is registered, stepped through the sequencer into the
// result buffer, and from there can be taken on the result channel.
// Throughput: one tick beat per cycle while the result side keeps up; result stalls fill the
// two-entry buffer and then hold the input, and the buffer loses no beat.
// Reset (synchronous, active high): sequencer idle, buffers empty, registers at defaults.
// Depends on i2cee_pkg, i2cee_if, i2cee_csr, i2cee_core and i2cee_outq.
module i2c_eeprom_byte_access_master
   import i2cee_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   i2cee_req_if.sink             req,
   i2cee_rsp_if.source           rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type      cfg;       // live configuration, wait lengths pre-scaled
   rsp_item_type step_rsp;  // line levels and flags for the stepped tick
   logic         step_push;
   logic         q_full;

   // Register file: scaled waits are computed once when wait_scale is written
   i2cee_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: START, address/data bytes with ack polling, read bits, STOP,
   // then for writes the write cycle hold; one phase step per tick beat
   i2cee_core u_core (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .cfg    (cfg),
      .q_full (q_full),
      .push   (step_push),
      .result (step_rsp)
   );

   // Result buffer; the sequencer stalls only when both entries wait
   i2cee_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (step_push),
      .item  (step_rsp),
      .full  (q_full),
      .rsp   (rsp)
   );

endmodule

// ===== rtl/i2cee_checker.sv =====
// Port-level checks on the result beats of the EEPROM byte access master.
// Depends on i2cee_pkg; bound to the top level at the end of this file.
module i2cee_checker
   import i2cee_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl,
   input logic       rsp_sda_out,
   input logic       rsp_busy_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_read_done,
   input logic       rsp_ack_missed
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_scl) && $stable(rsp_sda_out) && $stable(rsp_busy_res))
      else $error("result beat changed while stalled");

   // idle ticks release both lines and raise no flags
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl && rsp_sda_out && !rsp_read_done
         && !rsp_ack_missed)
      else $error("idle tick drives the bus or flags");

   // read completes on the STOP tick with both lines released
   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_done |-> rsp_busy_res && rsp_scl && rsp_sda_out
         && !rsp_ack_missed)
      else $error("read_done outside the final STOP tick");

   // timeout happens during the acknowledge clock high with SDA released
   a_ack_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_missed |-> rsp_busy_res && rsp_scl && rsp_sda_out)
      else $error("ack_missed outside an acknowledge slot");

endmodule

bind i2c_eeprom_byte_access_master i2cee_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_scl        (rsp.scl),
   .rsp_sda_out    (rsp.sda_out),
   .rsp_busy_res   (rsp.busy_res),
   .rsp_read_data  (rsp.read_data),
   .rsp_read_done  (rsp.read_done),
   .rsp_ack_missed (rsp.ack_missed)
);
